### rtl/ddmm_pkg.sv
`timescale 1ns / 1ps

package ddmm_pkg;

  // ascii codes
  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_POINT = 8'h2E;

  // string length limit, default for the top level parameter
  localparam int MAX_LEN_DEF = 16;

  // character counter width, holds the largest allowed limit
  localparam int CNT_W = 5;

  localparam int DEG_W  = 10;
  localparam int MIN_W  = 50;
  localparam int FDC_W  = 5;
  localparam int DEN_W  = 60;
  localparam int REM_W  = 54;
  localparam int SUB_W  = DEN_W + 1;

  localparam logic [FDC_W-1:0] FDC_MAX  = 5'd31;
  localparam logic [FDC_W-1:0] FDC_CLIP = 5'd16;

  localparam int DEN_ENTRIES = 17;

  // 60 * 10^k for k fraction digits of minutes
  localparam logic [DEN_W-1:0] DEN_TABLE [DEN_ENTRIES] = '{
    60'd60,
    60'd600,
    60'd6000,
    60'd60000,
    60'd600000,
    60'd6000000,
    60'd60000000,
    60'd600000000,
    60'd6000000000,
    60'd60000000000,
    60'd600000000000,
    60'd6000000000000,
    60'd60000000000000,
    60'd600000000000000,
    60'd6000000000000000,
    60'd60000000000000000,
    60'd600000000000000000
  };

  typedef struct packed {
    logic [7:0] in_char;
    logic       is_longitude;
    logic       in_last;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_char;
    logic       out_last;
  } out_item_t;

  // accumulated string, loader to sequencer
  typedef struct packed {
    logic [CNT_W-1:0] count;
    logic [DEG_W-1:0] degrees;
    logic [MIN_W-1:0] minutes;
    logic [FDC_W-1:0] frac_digits;
    logic             lon;
  } ldr_stat_t;

endpackage

### rtl/ddmm_sub_unit.sv
`timescale 1ns / 1ps

module ddmm_sub_unit import ddmm_pkg::*; (
  input  logic [SUB_W-1:0] a_i,
  input  logic [SUB_W-1:0] b_i,
  output logic [SUB_W-1:0] diff_o,
  output logic             ge_o
);

  logic [SUB_W:0] full;

  // borrow out clear means a >= b
  assign full   = {1'b0, a_i} - {1'b0, b_i};
  assign diff_o = full[SUB_W-1:0];
  assign ge_o   = ~full[SUB_W];

endmodule

### rtl/ddmm_loader.sv
`timescale 1ns / 1ps

module ddmm_loader import ddmm_pkg::*; #(
  parameter int MAX_LEN = MAX_LEN_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      take_i,
  input  in_item_t  item_i,
  input  logic      clear_i,
  output ldr_stat_t stat_o
);

  logic [CNT_W-1:0] count_q, count_d;
  logic [DEG_W-1:0] deg_q, deg_d;
  logic [MIN_W-1:0] min_q, min_d;
  logic [FDC_W-1:0] fdc_q, fdc_d;
  logic             point_q, point_d;
  logic             lon_q, lon_d;
  logic             lon_eff;
  logic [CNT_W-1:0] digits;
  logic [3:0]       nib;

  always_comb begin
    count_d = count_q;
    deg_d   = deg_q;
    min_d   = min_q;
    fdc_d   = fdc_q;
    point_d = point_q;
    lon_d   = lon_q;
    lon_eff = (count_q == '0) ? item_i.is_longitude : lon_q;
    digits  = lon_eff ? CNT_W'(3) : CNT_W'(2);
    nib     = item_i.in_char[3:0];
    if (clear_i) begin
      count_d = '0;
      deg_d   = '0;
      min_d   = '0;
      fdc_d   = '0;
      point_d = 1'b0;
      lon_d   = 1'b0;
    end else if (take_i) begin
      lon_d = lon_eff;
      if (count_q < CNT_W'(MAX_LEN)) begin
        count_d = count_q + CNT_W'(1);
        if (count_q < digits) begin
          // degree positions take every character as its low nibble
          deg_d = (deg_q << 3) + (deg_q << 1) + {{(DEG_W-4){1'b0}}, nib};
        end else if (item_i.in_char == CHAR_POINT) begin
          point_d = 1'b1;
        end else begin
          min_d = (min_q << 3) + (min_q << 1) + {{(MIN_W-4){1'b0}}, nib};
          if (point_q && (fdc_q != FDC_MAX)) begin
            fdc_d = fdc_q + FDC_W'(1);
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      deg_q   <= '0;
      min_q   <= '0;
      fdc_q   <= '0;
      point_q <= 1'b0;
      lon_q   <= 1'b0;
    end else begin
      count_q <= count_d;
      deg_q   <= deg_d;
      min_q   <= min_d;
      fdc_q   <= fdc_d;
      point_q <= point_d;
      lon_q   <= lon_d;
    end
  end

  assign stat_o.count       = count_q;
  assign stat_o.degrees     = deg_q;
  assign stat_o.minutes     = min_q;
  assign stat_o.frac_digits = fdc_q;
  assign stat_o.lon         = lon_q;

endmodule

### rtl/ddmm_seq.sv
`timescale 1ns / 1ps

module ddmm_seq import ddmm_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  ldr_stat_t        stat_i,
  output logic             clear_o,
  output logic             busy_o,
  output logic [SUB_W-1:0] sub_a_o,
  output logic [SUB_W-1:0] sub_b_o,
  input  logic [SUB_W-1:0] sub_diff_i,
  input  logic             sub_ge_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output out_item_t        out_data_o
);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_LOAD  = 4'd1;
  localparam logic [3:0] S_DIV_A = 4'd2;
  localparam logic [3:0] S_DIV_B = 4'd3;
  localparam logic [3:0] S_SUM   = 4'd4;
  localparam logic [3:0] S_RED   = 4'd5;
  localparam logic [3:0] S_HUND  = 4'd6;
  localparam logic [3:0] S_TENS  = 4'd7;
  localparam logic [3:0] S_EMIT  = 4'd8;
  localparam logic [3:0] S_FRAC  = 4'd9;

  localparam int BIT_W = $clog2(MIN_W);
  localparam int ACC_W = 11;

  logic [3:0]       state_q, state_d;
  logic [DEN_W-1:0] den_q, den_d;
  logic [DEN_W-1:0] work_q, work_d;
  logic [MIN_W-1:0] dvd_q, dvd_d;
  logic [BIT_W-1:0] bit_q, bit_d;
  logic             qbit_q, qbit_d;
  logic [ACC_W-1:0] acc_q, acc_d;
  logic [DEG_W-1:0] deg_q, deg_d;
  logic             lon_q, lon_d;
  logic [CNT_W-1:0] total_q, total_d;
  logic [CNT_W-1:0] idx_q, idx_d;
  logic [3:0]       dig_h_q, dig_h_d;
  logic [3:0]       dig_t_q, dig_t_d;
  logic [3:0]       dig_u_q, dig_u_d;
  logic [3:0]       fdig_q, fdig_d;
  logic             frdy_q, frdy_d;
  logic             oval_q, oval_d;
  out_item_t        odat_q, odat_d;

  logic [ACC_W-1:0] modulus;
  logic [CNT_W-1:0] digits;
  logic [1:0]       pos;
  logic [3:0]       deg_digit;
  logic [7:0]       ch;
  logic             have;
  logic             out_free;

  always_comb begin
    state_d = state_q;
    den_d   = den_q;
    work_d  = work_q;
    dvd_d   = dvd_q;
    bit_d   = bit_q;
    qbit_d  = qbit_q;
    acc_d   = acc_q;
    deg_d   = deg_q;
    lon_d   = lon_q;
    total_d = total_q;
    idx_d   = idx_q;
    dig_h_d = dig_h_q;
    dig_t_d = dig_t_q;
    dig_u_d = dig_u_q;
    fdig_d  = fdig_q;
    frdy_d  = frdy_q;
    oval_d  = oval_q;
    odat_d  = odat_q;
    clear_o = 1'b0;
    sub_a_o = '0;
    sub_b_o = '0;
    ch      = CHAR_POINT;
    have    = 1'b0;

    modulus  = lon_q ? ACC_W'(1000) : ACC_W'(100);
    digits   = lon_q ? CNT_W'(3) : CNT_W'(2);
    pos      = idx_q[1:0] + (lon_q ? 2'd0 : 2'd1);
    out_free = ~oval_q | ~out_stall_i;

    case (pos)
      2'd0:    deg_digit = dig_h_q;
      2'd1:    deg_digit = dig_t_q;
      default: deg_digit = dig_u_q;
    endcase

    if (!out_stall_i) begin
      oval_d = 1'b0;
    end

    unique case (state_q)
      S_IDLE: begin
        if (start_i) begin
          state_d = S_LOAD;
        end
      end
      S_LOAD: begin
        den_d   = (stat_i.frac_digits > FDC_CLIP) ? DEN_TABLE[FDC_CLIP]
                                                  : DEN_TABLE[stat_i.frac_digits];
        work_d  = '0;
        dvd_d   = stat_i.minutes;
        bit_d   = BIT_W'(MIN_W - 1);
        acc_d   = '0;
        deg_d   = stat_i.degrees;
        lon_d   = stat_i.lon;
        total_d = stat_i.count;
        idx_d   = '0;
        frdy_d  = 1'b0;
        clear_o = 1'b1;
        state_d = S_DIV_A;
      end
      S_DIV_A: begin
        // restoring division step on minutes / den
        sub_a_o = {work_q, dvd_q[MIN_W-1]};
        sub_b_o = {1'b0, den_q};
        dvd_d   = dvd_q << 1;
        qbit_d  = sub_ge_i;
        work_d  = sub_ge_i ? sub_diff_i[DEN_W-1:0] : sub_a_o[DEN_W-1:0];
        state_d = S_DIV_B;
      end
      S_DIV_B: begin
        // quotient kept modulo the degree range
        sub_a_o = {{(SUB_W-ACC_W){1'b0}}, acc_q[ACC_W-2:0], qbit_q};
        sub_b_o = {{(SUB_W-ACC_W){1'b0}}, modulus};
        acc_d   = sub_ge_i ? sub_diff_i[ACC_W-1:0] : sub_a_o[ACC_W-1:0];
        if (bit_q == '0) begin
          state_d = S_SUM;
        end else begin
          bit_d   = bit_q - BIT_W'(1);
          state_d = S_DIV_A;
        end
      end
      S_SUM: begin
        acc_d   = acc_q + {{(ACC_W-DEG_W){1'b0}}, deg_q};
        dig_h_d = '0;
        dig_t_d = '0;
        state_d = S_RED;
      end
      S_RED: begin
        sub_a_o = {{(SUB_W-ACC_W){1'b0}}, acc_q};
        sub_b_o = {{(SUB_W-ACC_W){1'b0}}, modulus};
        if (sub_ge_i) begin
          acc_d = sub_diff_i[ACC_W-1:0];
        end else begin
          state_d = lon_q ? S_HUND : S_TENS;
        end
      end
      S_HUND: begin
        sub_a_o = {{(SUB_W-ACC_W){1'b0}}, acc_q};
        sub_b_o = SUB_W'(100);
        if (sub_ge_i) begin
          acc_d   = sub_diff_i[ACC_W-1:0];
          dig_h_d = dig_h_q + 4'd1;
        end else begin
          state_d = S_TENS;
        end
      end
      S_TENS: begin
        sub_a_o = {{(SUB_W-ACC_W){1'b0}}, acc_q};
        sub_b_o = SUB_W'(10);
        if (sub_ge_i) begin
          acc_d   = sub_diff_i[ACC_W-1:0];
          dig_t_d = dig_t_q + 4'd1;
        end else begin
          dig_u_d = acc_q[3:0];
          state_d = S_EMIT;
        end
      end
      S_EMIT: begin
        if (idx_q < digits) begin
          ch   = CHAR_ZERO + {4'd0, deg_digit};
          have = 1'b1;
        end else if (idx_q == digits) begin
          ch   = CHAR_POINT;
          have = 1'b1;
        end else if (frdy_q) begin
          ch   = CHAR_ZERO + {4'd0, fdig_q};
          have = 1'b1;
        end else begin
          // next fraction digit: remainder times ten over den
          work_d  = (work_q << 3) + (work_q << 1);
          fdig_d  = '0;
          state_d = S_FRAC;
        end
        if (have && out_free) begin
          oval_d          = 1'b1;
          odat_d.out_char = ch;
          odat_d.out_last = (idx_q + CNT_W'(1) == total_q);
          frdy_d          = 1'b0;
          if (idx_q + CNT_W'(1) == total_q) begin
            state_d = S_IDLE;
          end else begin
            idx_d = idx_q + CNT_W'(1);
          end
        end
      end
      S_FRAC: begin
        sub_a_o = {1'b0, work_q};
        sub_b_o = {1'b0, den_q};
        if (sub_ge_i) begin
          work_d = sub_diff_i[DEN_W-1:0];
          fdig_d = fdig_q + 4'd1;
        end else begin
          work_d  = {{(DEN_W-REM_W){1'b0}}, work_q[REM_W-1:0]};
          frdy_d  = 1'b1;
          state_d = S_EMIT;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      oval_q  <= 1'b0;
      frdy_q  <= 1'b0;
      idx_q   <= '0;
      total_q <= '0;
      bit_q   <= '0;
      lon_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      oval_q  <= oval_d;
      frdy_q  <= frdy_d;
      idx_q   <= idx_d;
      total_q <= total_d;
      bit_q   <= bit_d;
      lon_q   <= lon_d;
    end
  end

  always_ff @(posedge clk_i) begin
    den_q   <= den_d;
    work_q  <= work_d;
    dvd_q   <= dvd_d;
    qbit_q  <= qbit_d;
    acc_q   <= acc_d;
    deg_q   <= deg_d;
    dig_h_q <= dig_h_d;
    dig_t_q <= dig_t_d;
    dig_u_q <= dig_u_d;
    fdig_q  <= fdig_d;
    odat_q  <= odat_d;
  end

  assign busy_o      = (state_q != S_IDLE);
  assign out_valid_o = oval_q;
  assign out_data_o  = odat_q;

endmodule

### rtl/ddmm_to_decimal_degrees_ascii.sv
`timescale 1ns / 1ps
// nmea coordinate to decimal degrees, ascii in and ascii out
// input channel: one character per transaction (in_valid_i, in_stall_o, in_data_i);
//   is_longitude on the first character picks 3 degree digits over 2,
//   in_last on the final character starts the conversion
// output channel: as many characters as were kept (at most MAX_LEN) on out_data_o,
//   out_last set on the final one
// characters are taken one per cycle while the block is idle
// after the last character in_stall_o stays high for the conversion:
//   a load step, bit-serial division (S_DIV_A then S_DIV_B per quotient bit),
//   an add, the modulo steps, the digit steps, then for each output
//   character an emit step, plus the subtract steps of each fraction digit
// the single 61-bit subtract/compare unit is shared by the division, modulo,
// digit and fraction steps
// output goes through a register: a stalled receiver holds the character and
//   stops the sequencer at its next output character; once the final character is registered the block
//   takes the next string while that character waits
// reset clears the accumulators, the sequencer and the output valid

module ddmm_to_decimal_degrees_ascii import ddmm_pkg::*; #(
  parameter int MAX_LEN = MAX_LEN_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  in_item_t  in_data_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_item_t out_data_o
);

  logic             busy;
  logic             take;
  logic             start;
  logic             clear;
  ldr_stat_t        stat;
  logic [SUB_W-1:0] sub_a;
  logic [SUB_W-1:0] sub_b;
  logic [SUB_W-1:0] sub_diff;
  logic             sub_ge;

  // characters are only taken while no conversion is running
  assign in_stall_o = busy;
  assign take       = in_valid_i & ~busy;
  assign start      = take & in_data_i.in_last;

  // character accumulation
  ddmm_loader #(
    .MAX_LEN(MAX_LEN)
  ) u_loader (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .take_i (take),
    .item_i (in_data_i),
    .clear_i(clear),
    .stat_o (stat)
  );

  // shared subtract and compare
  ddmm_sub_unit u_sub (
    .a_i   (sub_a),
    .b_i   (sub_b),
    .diff_o(sub_diff),
    .ge_o  (sub_ge)
  );

  // division, digit extraction and output sequencing
  ddmm_seq u_seq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (start),
    .stat_i     (stat),
    .clear_o    (clear),
    .busy_o     (busy),
    .sub_a_o    (sub_a),
    .sub_b_o    (sub_b),
    .sub_diff_i (sub_diff),
    .sub_ge_i   (sub_ge),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o)
  );

endmodule

### dv/tb.sv
`timescale 1ns / 1ps

module tb;
  import ddmm_pkg::*;

  localparam int HOLD_CYCLES = 1000;
  localparam int DRAIN_CYCLES = 400;
  localparam logic [63:0] REM_MASK = (64'd1 << REM_W) - 64'd1;

  // directed strings; an empty wanted string means the predictor decides
  localparam int DIR_ROWS = 5;
  string dir_text [DIR_ROWS] = '{"4", "99", "9960.00", "18000.0", "\xFF7959.9.9A9999999"};
  bit    dir_lon  [DIR_ROWS] = '{1'b0, 1'b0, 1'b0, 1'b1, 1'b1};
  string dir_want [DIR_ROWS] = '{"0", "99", "00.0000", "180.000", ""};

  logic      clk;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_stall;
  in_item_t  in_data = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_item_t out_data;

  // predictor copy of the string accumulator
  logic [CNT_W-1:0] acc_count = '0;
  logic [DEG_W-1:0] acc_deg = '0;
  logic [MIN_W-1:0] acc_min = '0;
  logic [FDC_W-1:0] acc_frac = '0;
  logic             acc_point = 1'b0;
  logic             acc_lon = 1'b0;

  out_item_t   conv_out [$];
  out_item_t   due_chars [$];
  logic [7:0]  fix_chars [$];

  int unsigned tx_gap_pct = 0;
  int unsigned rx_stall_pct = 0;
  int unsigned hold_asks = 0;
  int unsigned err_cnt = 0;
  int unsigned n_in = 0;
  int unsigned n_str = 0;
  int unsigned n_out = 0;

  ddmm_to_decimal_degrees_ascii dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall),
    .in_data_i  (in_data),
    .out_valid_o(out_valid),
    .out_stall_i(out_stall),
    .out_data_o (out_data)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // generous limit, 30 ms
  initial begin
    #(30_000_000);
    $display("TEST FAILED");
    $finish;
  end

  // mostly short gaps, now and then a long one
  function automatic int unsigned pick_gap();
    int unsigned roll = $urandom_range(1, 100);
    if (roll <= 80) return $urandom_range(1, 3);
    if (roll <= 95) return $urandom_range(4, 15);
    return $urandom_range(30, 80);
  endfunction

  // takes one character; on the last one fills conv_out with the degree string
  function automatic void convert_char(input in_item_t it);
    int unsigned ndig, idx, k;
    logic [63:0] den, whole, rem, r, p;
    out_item_t o;
    conv_out.delete();
    if (acc_count == 0) acc_lon = it.is_longitude;
    ndig = acc_lon ? 3 : 2;
    if (acc_count < MAX_LEN_DEF) begin
      if (acc_count < ndig) begin
        acc_deg = DEG_W'(acc_deg * 10 + it.in_char[3:0]);
      end else if (it.in_char == CHAR_POINT) begin
        acc_point = 1'b1;
      end else begin
        acc_min = acc_min * 10 + it.in_char[3:0];
        if (acc_point && acc_frac < FDC_MAX) acc_frac++;
      end
      acc_count++;
    end
    if (!it.in_last) return;

    den = 64'd60;
    for (k = 0; k < acc_frac && k < 16; k++) den = den * 10;
    whole = 64'(acc_deg) + 64'(acc_min) / den;
    rem = (64'(acc_min) % den) & REM_MASK;
    whole = whole % (acc_lon ? 64'd1000 : 64'd100);

    for (idx = 0; idx < acc_count; idx++) begin
      if (idx < ndig) begin
        p = 64'd1;
        for (k = idx + 1; k < ndig; k++) p = p * 10;
        o.out_char = CHAR_ZERO + 8'((whole / p) % 10);
      end else if (idx == ndig) begin
        o.out_char = CHAR_POINT;
      end else begin
        // next digit of the exact long division
        r = rem * 10;
        o.out_char = CHAR_ZERO + 8'(r / den);
        rem = (r % den) & REM_MASK;
      end
      o.out_last = (idx + 1 == acc_count);
      conv_out.push_back(o);
    end

    acc_count = '0;
    acc_deg = '0;
    acc_min = '0;
    acc_frac = '0;
    acc_point = 1'b0;
    acc_lon = 1'b0;
  endfunction

  // random character for broken strings, extremes weighted in
  function automatic logic [7:0] rand_byte();
    int unsigned roll;
    roll = $urandom_range(0, 5);
    if (roll <= 1) return CHAR_ZERO + 8'($urandom_range(0, 9));
    if (roll == 2) return CHAR_POINT;
    if (roll == 3) return $urandom_range(0, 1) ? 8'hFF : 8'h00;
    return 8'($urandom_range(0, 255));
  endfunction

  // fills fix_chars with one coordinate string of the chosen kind
  function automatic void make_fix(input bit lon, input int unsigned kind);
    int unsigned ndig, nfrac, len;
    ndig = lon ? 3 : 2;
    fix_chars.delete();
    if (kind == 7) begin
      // garbage of any length, overlong included
      len = $urandom_range(1, 20);
      repeat (len) fix_chars.push_back(rand_byte());
      return;
    end
    if (kind == 9) begin
      // cut short around the degree digits
      len = $urandom_range(1, ndig + 1);
      repeat (len) fix_chars.push_back(CHAR_ZERO + 8'($urandom_range(0, 9)));
      if ($urandom_range(0, 1)) fix_chars.push_back(CHAR_POINT);
      return;
    end
    nfrac = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 13 - ndig) : $urandom_range(3, 5);
    repeat (ndig + 2) fix_chars.push_back(CHAR_ZERO + 8'($urandom_range(0, 9)));
    if (nfrac != 0 || $urandom_range(0, 1)) fix_chars.push_back(CHAR_POINT);
    repeat (nfrac) fix_chars.push_back(CHAR_ZERO + 8'($urandom_range(0, 9)));
    if (kind == 8) begin
      // well formed but with a bad character and maybe a tail past the limit
      fix_chars[$urandom_range(0, fix_chars.size() - 1)] = rand_byte();
      if ($urandom_range(0, 1)) repeat ($urandom_range(1, 8)) fix_chars.push_back(rand_byte());
    end
  endfunction

  // one input transaction; expectations are queued when it is accepted
  task automatic put_char(input in_item_t it, input string want);
    int unsigned gap;
    out_item_t o;
    in_valid <= 1'b1;
    in_data <= it;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    n_in++;
    convert_char(it);
    if (it.in_last) begin
      n_str++;
      if (want.len() == 0) begin
        foreach (conv_out[i]) due_chars.push_back(conv_out[i]);
      end else begin
        for (int i = 0; i < want.len(); i++) begin
          o.out_char = want[i];
          o.out_last = (i == want.len() - 1);
          due_chars.push_back(o);
        end
      end
    end
    gap = ($urandom_range(1, 100) <= tx_gap_pct) ? pick_gap() : 0;
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // is_longitude only counts on the first character, so the rest get noise
  task automatic send_text(input logic [7:0] chars [$], input bit lon, input string want);
    in_item_t it;
    foreach (chars[i]) begin
      it.in_char = chars[i];
      it.is_longitude = (i == 0) ? lon : 1'($urandom_range(0, 1));
      it.in_last = (i == chars.size() - 1);
      put_char(it, want);
    end
  endtask

  task automatic send_fix();
    bit lon;
    lon = 1'($urandom_range(0, 1));
    make_fix(lon, $urandom_range(0, 9));
    send_text(fix_chars, lon, "");
  endtask

  // sender idles while the expected results come out
  task automatic wait_drained();
    in_valid <= 1'b0;
    while (due_chars.size() != 0) @(posedge clk);
  endtask

  // result checker and receiver stall generator
  initial begin : result_check
    out_item_t want;
    int unsigned hold_left, hold_taken, stall_left;
    hold_left = 0;
    hold_taken = 0;
    stall_left = 0;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && !out_stall) begin
        if (due_chars.size() == 0) begin
          err_cnt++;
          $error("out_char: expected nothing, got %h (out_last %b)",
                 out_data.out_char, out_data.out_last);
        end else begin
          want = due_chars.pop_front();
          n_out++;
          if (out_data.out_char !== want.out_char) begin
            err_cnt++;
            $error("out_char: expected %h, got %h", want.out_char, out_data.out_char);
          end
          if (out_data.out_last !== want.out_last) begin
            err_cnt++;
            $error("out_last: expected %b, got %b", want.out_last, out_data.out_last);
          end
        end
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else if (hold_taken != hold_asks) begin
        // long hold-off so the block backs up into its input
        hold_taken++;
        hold_left = HOLD_CYCLES - 1;
        out_stall <= 1'b1;
      end else if (stall_left > 0) begin
        stall_left--;
        out_stall <= 1'b1;
      end else if ($urandom_range(1, 100) <= rx_stall_pct) begin
        stall_left = pick_gap() - 1;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  initial begin : stimulus
    logic [7:0] txt [$];
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: short strings, degree wrap (99 deg + 60 min), longitude,
    // an overlong string with a bad byte, repeated point and dropped last
    for (int r = 0; r < DIR_ROWS; r++) begin
      txt.delete();
      for (int j = 0; j < dir_text[r].len(); j++) txt.push_back(dir_text[r][j]);
      send_text(txt, dir_lon[r], dir_want[r]);
    end

    // back to back, no idling
    while (n_in < 100) send_fix();

    tx_gap_pct = 30;
    rx_stall_pct <= 30;
    while (n_in < 200) send_fix();

    // receiver holds off while strings keep coming
    tx_gap_pct = 0;
    hold_asks <= hold_asks + 1;
    repeat (3) send_fix();
    wait_drained();

    tx_gap_pct = 50;
    rx_stall_pct <= 50;
    while (n_in < 300) send_fix();
    wait_drained();

    tx_gap_pct = 15;
    rx_stall_pct <= 10;
    while (n_in < 380) send_fix();
    in_valid <= 1'b0;

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("%0d characters in, %0d strings converted, %0d result characters checked",
             n_in, n_str, n_out);
    $display("covered wraps, short and overlong strings, bad bytes, hold-off and full drains");
    if (err_cnt == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

### sim.f
rtl/ddmm_pkg.sv
rtl/ddmm_sub_unit.sv
rtl/ddmm_loader.sv
rtl/ddmm_seq.sv
rtl/ddmm_to_decimal_degrees_ascii.sv
dv/tb.sv
